// ===== rtl/core/adfp_pkg.sv =====
package adfp_pkg;

    localparam int VALUE_W        = 48;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int CUT_W          = 2;
    localparam int FLAG_W         = 3;

    localparam int INT_BITS_DEF        = 32;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 6;

    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_POINT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;

    localparam logic [CUT_W-1:0] CUT_NEVER  = 2'b11;
    localparam logic [CUT_W-1:0] CUT_SPACE  = 2'b00;
    localparam logic [CUT_W-1:0] CUT_ALWAYS = 2'b01;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_INT   = 3'b010,
        PH_FRAC  = 3'b100
    } phase_t;

    typedef struct packed {
        logic               is_digit;
        logic               is_minus;
        logic               is_point;
        logic               is_space;
        logic [DIGIT_W-1:0] digit;
    } item_t;

    typedef struct packed {
        logic negative;
        logic no_digits;
        logic saturated;
        logic consumed;
    } term_t;

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        case (n)
            0: p = 32'd1;
            1: p = 32'd10;
            2: p = 32'd100;
            3: p = 32'd1000;
            4: p = 32'd10000;
            5: p = 32'd100000;
            6: p = 32'd1000000;
            7: p = 32'd10000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    function automatic int value_bits(input int ib, input int fb);
        return (ib + fb > VALUE_W) ? VALUE_W : ib + fb;
    endfunction

    function automatic int int_width(input int ib, input int fb);
        return value_bits(ib, fb) - 1 - fb;
    endfunction

    function automatic int frac_width(input int mfd);
        return $clog2(pow10(mfd) + 32'd1);
    endfunction

endpackage

// ===== rtl/core/adfp_front.sv =====
module adfp_front
    import adfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,
    output logic              push,
    output item_t             push_item,
    input  logic              q_full
);

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;
    logic  is_digit;

    always_comb
    begin
        is_digit            = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
        item_next.is_digit  = is_digit;
        item_next.is_minus  = (s_axis_tdata == CHAR_MINUS);
        item_next.is_point  = (s_axis_tdata == CHAR_POINT);
        item_next.is_space  = (s_axis_tdata == CHAR_SPACE) || (s_axis_tdata == CHAR_NEWLINE);
        item_next.digit     = DIGIT_W'(s_axis_tdata - CHAR_ZERO);
    end

    assign s_axis_tready = !vld_reg || !q_full;
    assign push          = vld_reg && !q_full;
    assign push_item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/adfp_queue.sv =====
module adfp_queue
    import adfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

endmodule

// ===== rtl/core/adfp_back.sv =====
module adfp_back
    import adfp_pkg::*;
#(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  item_t                              head_item,
    output logic                               pop,
    input  logic [CUT_W-1:0]                   cut_mode,
    input  logic                               div_ready,
    output logic                               term_valid,
    output term_t                              term_flags,
    output logic [int_width(INT_BITS, FRAC_BITS)-1:0] term_int,
    output logic [frac_width(MAX_FRAC_DIGITS)-1:0]    term_frac,
    output logic [$clog2(MAX_FRAC_DIGITS + 1)-1:0]    term_pos
);

    localparam int IW = int_width(INT_BITS, FRAC_BITS);
    localparam int DW = frac_width(MAX_FRAC_DIGITS);
    localparam int PW = $clog2(MAX_FRAC_DIGITS + 1);

    phase_t          phase_reg, phase_next;
    logic            neg_reg, neg_next;
    logic            seen_reg, seen_next;
    logic [IW-1:0]   int_reg, int_next;
    logic [DW-1:0]   frac_reg, frac_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic            ovf_reg, ovf_next;
    logic [IW+3:0]   int_mul;
    logic [DW+3:0]   frac_mul;
    logic            in_int;
    logic            terminate;

    assign pop = q_valid && div_ready;

    always_comb
    begin
        int_mul  = {1'b0, int_reg, 3'b000} + {3'b000, int_reg, 1'b0}
                 + (IW+4)'(head_item.digit);
        frac_mul = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0}
                 + (DW+4)'(head_item.digit);
        in_int   = (phase_reg == PH_INT) || ((phase_reg == PH_START) && !head_item.is_minus);

        phase_next = phase_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        terminate  = 1'b0;

        if (pop)
        begin
            if ((phase_reg == PH_START) && head_item.is_minus)
            begin
                neg_next   = 1'b1;
                phase_next = PH_INT;
            end
            else if (in_int)
            begin
                if (head_item.is_digit)
                begin
                    phase_next = PH_INT;
                    seen_next  = 1'b1;
                    if (ovf_reg || (int_mul[IW+3:IW] != '0))
                    begin
                        int_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        int_next = int_mul[IW-1:0];
                    end
                end
                else if (head_item.is_point)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    terminate = 1'b1;
                end
            end
            else if (head_item.is_digit)
            begin
                seen_next = 1'b1;
                if (pos_reg < PW'(MAX_FRAC_DIGITS))
                begin
                    frac_next = frac_mul[DW-1:0];
                    pos_next  = pos_reg + PW'(1);
                end
            end
            else
            begin
                terminate = 1'b1;
            end
        end

        if (terminate)
        begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            pos_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    assign term_valid           = terminate;
    assign term_flags.negative  = neg_reg;
    assign term_flags.no_digits = !seen_reg;
    assign term_flags.saturated = ovf_reg && seen_reg;
    assign term_flags.consumed  = (cut_mode == CUT_ALWAYS)
                               || ((cut_mode == CUT_SPACE) && head_item.is_space);
    assign term_int             = int_reg;
    assign term_frac            = frac_reg;
    assign term_pos             = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) ovf_reg |-> (int_reg == '1))
        else $error("overflow without clamped integer part");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_FRAC_DIGITS))
        else $error("fraction position beyond digit limit");

endmodule

// ===== rtl/core/adfp_divider.sv =====
module adfp_divider
    import adfp_pkg::*;
#(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               term_valid,
    input  term_t                              term_flags,
    input  logic [int_width(INT_BITS, FRAC_BITS)-1:0] term_int,
    input  logic [frac_width(MAX_FRAC_DIGITS)-1:0]    term_frac,
    input  logic [$clog2(MAX_FRAC_DIGITS + 1)-1:0]    term_pos,
    output logic                               div_ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [VALUE_W-1:0]                 m_axis_tdata,
    output logic [FLAG_W-1:0]                  m_axis_tuser
);

    localparam int IW = int_width(INT_BITS, FRAC_BITS);
    localparam int DW = frac_width(MAX_FRAC_DIGITS);
    localparam int FB = FRAC_BITS;
    localparam logic [VALUE_W-1:0] NO_DIGIT_VALUE =
        ~(VALUE_W'(1) << FRAC_BITS) + VALUE_W'(1);

    logic [FB:0]     vld_reg;
    term_t           flg_reg [FB+1];
    logic [IW-1:0]   int_reg [FB+1];
    logic [DW-1:0]   rem_reg [FB+1];
    logic [DW-1:0]   dvs_reg [FB+1];
    logic [FB-1:0]   quo_reg [FB+1];

    logic [DW:0]     r2      [FB+1];
    logic [DW:0]     diff    [FB+1];
    logic            ge      [FB+1];
    logic [DW-1:0]   rem_nxt [FB+1];

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg, value_next;
    term_t               out_flg_reg;
    logic [VALUE_W-1:0]  mag;
    logic                adv;

    assign adv       = !out_valid_reg || m_axis_tready;
    assign div_ready = adv;

    always_comb
    begin
        for (int k = 0; k <= FB; k++)
        begin
            r2[k]      = {rem_reg[k], 1'b0};
            diff[k]    = r2[k] - {1'b0, dvs_reg[k]};
            ge[k]      = (r2[k] >= {1'b0, dvs_reg[k]});
            rem_nxt[k] = ge[k] ? diff[k][DW-1:0] : r2[k][DW-1:0];
        end
    end

    always_comb
    begin
        mag = VALUE_W'({int_reg[FB], quo_reg[FB]});
        if (flg_reg[FB].no_digits)
        begin
            value_next = NO_DIGIT_VALUE;
        end
        else if (flg_reg[FB].negative)
        begin
            value_next = ~mag + VALUE_W'(1);
        end
        else
        begin
            value_next = mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[FB-1:0], term_valid};
            out_valid_reg <= vld_reg[FB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flg_reg[0] <= term_flags;
            int_reg[0] <= term_int;
            rem_reg[0] <= term_frac;
            dvs_reg[0] <= DW'(pow10(int'(term_pos)));
            quo_reg[0] <= '0;
            for (int k = 1; k <= FB; k++)
            begin
                flg_reg[k] <= flg_reg[k-1];
                int_reg[k] <= int_reg[k-1];
                rem_reg[k] <= rem_nxt[k-1];
                dvs_reg[k] <= dvs_reg[k-1];
                quo_reg[k] <= {quo_reg[k-1][FB-2:0], ge[k-1]};
            end
            value_reg   <= value_next;
            out_flg_reg <= flg_reg[FB];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = {out_flg_reg.consumed, out_flg_reg.saturated, out_flg_reg.no_digits};

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FB] |-> (rem_reg[FB] < dvs_reg[FB]))
        else $error("fraction remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_flg_reg.no_digits && out_flg_reg.saturated))
        else $error("saturated result without digits");

endmodule

// ===== rtl/core/ascii_decimal_to_fixed_parser.sv =====
// Parses signed decimal numbers from an ASCII byte stream, one character per
// transaction, and returns each number as a signed fixed-point word with
// FRAC_BITS fraction bits (Q32.16 by default), truncated toward zero, with the
// integer part clamped when it overflows. A number is an optional leading
// minus, integer digits, an optional point and fraction digits; the first
// other character ends it and produces exactly one result. A number without
// digits returns -1.0 with no_digits set. cut_mode picks whether that
// terminating character was swallowed (terminator_consumed = 1) or must be
// sent again. The block takes one character every cycle without pause as long
// as results are drained. Each result is computed by the fraction-to-binary
// divider, a pipeline that resolves one quotient bit per stage, and is
// registered at its output. Write cut_mode only while the block is idle.
module ascii_decimal_to_fixed_parser
    import adfp_pkg::*;
#(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // character
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // value
    output logic [FLAG_W-1:0]  m_axis_tuser,   // no_digits, saturated, terminator_consumed
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CUT_W-1:0]   cfg_data        // cut_mode
);

    localparam int IW = int_width(INT_BITS, FRAC_BITS);
    localparam int DW = frac_width(MAX_FRAC_DIGITS);
    localparam int PW = $clog2(MAX_FRAC_DIGITS + 1);

    logic [CUT_W-1:0] cut_mode_reg;
    logic             push;
    item_t            push_item;
    logic             q_full;
    logic             pop;
    logic             q_valid;
    item_t            head_item;
    logic             div_ready;
    logic             term_valid;
    term_t            term_flags;
    logic [IW-1:0]    term_int;
    logic [DW-1:0]    term_frac;
    logic [PW-1:0]    term_pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_mode_reg <= CUT_SPACE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cut_mode_reg <= cfg_data;
        end
    end

    adfp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    adfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    adfp_back #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_item  (head_item),
        .pop        (pop),
        .cut_mode   (cut_mode_reg),
        .div_ready  (div_ready),
        .term_valid (term_valid),
        .term_flags (term_flags),
        .term_int   (term_int),
        .term_frac  (term_frac),
        .term_pos   (term_pos)
    );

    adfp_divider #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .term_valid    (term_valid),
        .term_flags    (term_flags),
        .term_int      (term_int),
        .term_frac     (term_frac),
        .term_pos      (term_pos),
        .div_ready     (div_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/ascii_decimal_to_fixed_parser_tb.sv =====
`timescale 1ns / 100ps

module ascii_decimal_to_fixed_parser_tb;
    import adfp_pkg::*;

    localparam int VAL_BITS = (INT_BITS_DEF + FRAC_BITS_DEF > VALUE_W) ?
                              VALUE_W : INT_BITS_DEF + FRAC_BITS_DEF;
    localparam longint unsigned MAX_MAG   = (64'd1 << (VAL_BITS - 1)) - 64'd1;
    localparam longint unsigned INT_LIMIT = MAX_MAG >> FRAC_BITS_DEF;

    localparam logic [CUT_W-1:0]  CUT_UNUSED = 2'b10;
    localparam logic [CHAR_W-1:0] CHAR_END   = 8'hff;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam int SETTLE_CYCLES   = FRAC_BITS_DEF + 24;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 170;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               no_digits;
        logic               saturated;
        logic               consumed;
    } number_result_t;

    class number_scoreboard;
        logic [CUT_W-1:0] cut_mode = CUT_SPACE;
        phase_t           phase = PH_START;
        bit               negative;
        bit               seen_digit;
        bit               overflow;
        longint unsigned  int_acc;
        longint unsigned  frac_acc;
        int               frac_pos;
        number_result_t   expected_q[$];
        int               mismatches;

        function void clear_number();
            phase      = PH_START;
            negative   = 1'b0;
            seen_digit = 1'b0;
            overflow   = 1'b0;
            int_acc    = 0;
            frac_acc   = 0;
            frac_pos   = 0;
        endfunction

        function void emit_number(logic [CHAR_W-1:0] c);
            number_result_t  r;
            longint unsigned scale;
            longint unsigned mag;
            if (seen_digit)
            begin
                scale = 1;
                for (int k = 0; k < frac_pos; k++)
                    scale = scale * 10;
                mag = (int_acc << FRAC_BITS_DEF) + (frac_acc << FRAC_BITS_DEF) / scale;
                if (mag > MAX_MAG)
                    mag = MAX_MAG;
                if (negative)
                    mag = 64'd0 - mag;
                r.value     = mag[VALUE_W-1:0];
                r.no_digits = 1'b0;
                r.saturated = overflow;
            end
            else
            begin
                mag         = 64'd0 - (64'd1 << FRAC_BITS_DEF);
                r.value     = mag[VALUE_W-1:0];
                r.no_digits = 1'b1;
                r.saturated = 1'b0;
            end
            r.consumed = (cut_mode == CUT_ALWAYS) ||
                         (cut_mode == CUT_SPACE && (c == CHAR_SPACE || c == CHAR_NEWLINE));
            expected_q.push_back(r);
            clear_number();
        endfunction

        // one accepted character transaction
        function void note_char(logic [CHAR_W-1:0] c);
            bit              is_digit;
            longint unsigned d;
            longint unsigned next;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            d = 64'(c - CHAR_ZERO);
            if (phase == PH_START)
            begin
                phase = PH_INT;
                if (c == CHAR_MINUS)
                begin
                    negative = 1'b1;
                    return;
                end
            end
            if (phase == PH_INT)
            begin
                if (is_digit)
                begin
                    seen_digit = 1'b1;
                    next = int_acc * 10 + d;
                    if (overflow || next > INT_LIMIT)
                    begin
                        int_acc  = INT_LIMIT;
                        overflow = 1'b1;
                    end
                    else
                        int_acc = next;
                    return;
                end
                if (c == CHAR_POINT)
                begin
                    phase = PH_FRAC;
                    return;
                end
            end
            else if (is_digit)
            begin
                seen_digit = 1'b1;
                if (frac_pos < MAX_FRAC_DIGITS_DEF)
                begin
                    frac_acc = frac_acc * 10 + d;
                    frac_pos++;
                end
                return;
            end
            emit_number(c);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [VALUE_W-1:0] value, logic [FLAG_W-1:0] flags);
            number_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %h flags %b", value, flags));
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %h, want %h", value, want.value));
            if (flags[0] !== want.no_digits)
                report_mismatch($sformatf("no_digits %b, want %b", flags[0], want.no_digits));
            if (flags[1] !== want.saturated)
                report_mismatch($sformatf("saturated %b, want %b", flags[1], want.saturated));
            if (flags[2] !== want.consumed)
                report_mismatch($sformatf("terminator_consumed %b, want %b",
                                          flags[2], want.consumed));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata = '0;   // character
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;        // value
    logic [FLAG_W-1:0]  m_axis_tuser;        // no_digits, saturated, terminator_consumed
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CUT_W-1:0]   cfg_data = '0;       // cut_mode

    number_scoreboard sb = new();
    bit idle_on = 1'b1;
    int hold_off_left = 0;
    int quiet_cycles = 0;
    int sent = 0;

    ascii_decimal_to_fixed_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver with random stalls and an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off_left--;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** ascii_decimal_to_fixed_parser: FAILED **");
            $finish;
        end
    end

    task automatic send_char(logic [CHAR_W-1:0] c);
        while (idle_on && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_char(c);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_digits(int n);
        repeat (n)
            send_char(CHAR_W'(CHAR_ZERO + $urandom_range(9)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_cut(logic [CUT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.cut_mode = v;
    endtask

    // mostly well-formed numbers, some raw noise and odd terminators
    task automatic send_random_number();
        int n_int;
        int n_frac;
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 4))
                send_char(CHAR_W'($urandom_range(255)));
            return;
        end
        if ($urandom_range(2) == 0)
            send_char(CHAR_MINUS);
        n_int = ($urandom_range(14) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 6);
        send_digits(n_int);
        if ($urandom_range(1) == 1)
        begin
            send_char(CHAR_POINT);
            n_frac = ($urandom_range(5) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
            send_digits(n_frac);
        end
        case ($urandom_range(7))
            0: send_char(CHAR_SPACE);
            1: send_char(CHAR_NEWLINE);
            2: send_char(CHAR_END);
            3: send_char(CHAR_MINUS);
            4: send_char(CHAR_POINT);
            default: send_char(CHAR_W'($urandom_range(255)));
        endcase
    endtask

    task automatic random_run(int n, bit with_hold, bit with_pause);
        int first;
        bit paused;
        first  = sent;
        paused = 1'b0;
        if (with_hold)
            hold_off_left = HOLD_OFF_CYCLES;
        while (sent - first < n)
        begin
            send_random_number();
            if (with_pause && !paused && sent - first >= n / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        // a space always closes whatever number is open
        send_char(CHAR_SPACE);
        wait_drained();
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cut(CUT_SPACE);
        send_text("7-");
        send_text("-0.5 ");
        send_text(".\n");
        send_text("-.");
        send_char(CHAR_NUL);
        send_text("1.2.");
        send_text("9999999999");
        send_char(CHAR_END);
        wait_drained();

        write_cut(CUT_ALWAYS);
        random_run(PHASE_ITEMS, 1'b1, 1'b0);

        write_cut(CUT_NEVER);
        idle_on = 1'b0;
        random_run(PHASE_ITEMS, 1'b0, 1'b0);
        idle_on = 1'b1;

        write_cut(CUT_UNUSED);
        random_run(PHASE_ITEMS, 1'b0, 1'b1);

        write_cut(CUT_SPACE);
        random_run(PHASE_ITEMS, 1'b0, 1'b0);

        if (sb.mismatches == 0)
            $display("** ascii_decimal_to_fixed_parser: PASSED **");
        else
            $display("** ascii_decimal_to_fixed_parser: FAILED **");
        $finish;
    end

endmodule

// ===== ascii_decimal_to_fixed_parser.f =====
rtl/core/adfp_pkg.sv
rtl/core/adfp_front.sv
rtl/core/adfp_queue.sv
rtl/core/adfp_back.sv
rtl/core/adfp_divider.sv
rtl/core/ascii_decimal_to_fixed_parser.sv
tb/ascii_decimal_to_fixed_parser_tb.sv
